// ===== design/pis_pkg.sv =====
`default_nettype none

package pis_pkg;

  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DT_W    = 16;
  localparam int AGE_W   = 31;
  localparam int DRAG_W  = 24;
  localparam int FAC_W   = 17;
  localparam int IN_W    = 376;
  localparam int OUT_W   = 256;

  localparam logic [FAC_W-1:0] FAC_ONE = 17'h10000;

  // Clamps a widened signed sum to the 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [33:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/pis_drag_factor.sv =====
`default_nettype none

module pis_drag_factor #(
  parameter int DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        ce,
  input  wire logic [pis_pkg::DRAG_W-1:0]  x_in,
  output logic      [pis_pkg::FAC_W-1:0]   fac
);
  import pis_pkg::*;

  localparam int IW        = $clog2(DEPTH + 1);
  localparam int PW        = 20 + IW;
  localparam int ROM_W     = FAC_W * (DEPTH + 1);
  localparam logic [63:0] ONE_Q56 = 64'd1 << 56;
  localparam logic [63:0] Y_STEP  = (64'd1 << 60) / DEPTH;

  function automatic logic [63:0] qmul56(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[119:56];
  endfunction

  // Entry i holds exp(-16*i/DEPTH) in Q1.16, built from a Taylor series in Q8.56.
  function automatic logic [ROM_W-1:0] build_rom();
    logic [63:0]      term;
    logic [63:0]      sum;
    logic [63:0]      cur;
    logic [63:0]      rnd;
    logic [ROM_W-1:0] r;
    term = ONE_Q56;
    sum  = ONE_Q56;
    cur  = ONE_Q56;
    r    = '0;
    for (int k = 1; k <= 24; k++) begin
      term = qmul56(term, Y_STEP) / 64'(k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r[0 +: FAC_W] = FAC_ONE;
    for (int i = 1; i <= DEPTH; i++) begin
      cur = qmul56(cur, sum);
      rnd = cur + (64'd1 << 39);
      r[i*FAC_W +: FAC_W] = rnd[56:40];
    end
    return r;
  endfunction

  localparam logic [ROM_W-1:0] ROM = build_rom();

  logic [PW-1:0]    p;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_hi;
  logic [FAC_W-1:0] ent_lo;
  logic [FAC_W-1:0] ent_hi;

  logic             zero_a;
  logic [FAC_W-1:0] base_a;
  logic [FAC_W-1:0] diff_a;
  logic [19:0]      frac_a;
  logic [FAC_W+19:0] prod;

  assign p      = PW'(x_in[19:0]) * PW'(DEPTH);
  assign idx    = p[PW-1:20];
  assign idx_hi = idx + IW'(1);
  assign ent_lo = ROM[idx*FAC_W +: FAC_W];
  assign ent_hi = ROM[idx_hi*FAC_W +: FAC_W];
  assign prod   = diff_a * frac_a;

  always_ff @(posedge clk) begin
    if (ce) begin
      zero_a <= (x_in[DRAG_W-1:20] != '0);
      base_a <= ent_lo;
      diff_a <= ent_lo - ent_hi;
      frac_a <= p[19:0];
      fac    <= zero_a ? '0 : base_a - prod[FAC_W+19:20];
    end
  end

endmodule

`default_nettype wire

// ===== design/pis_axis.sv =====
`default_nettype none

module pis_axis (
  input  wire logic                              clk,
  input  wire logic                              ce,
  input  wire logic        [pis_pkg::DT_W-1:0]   dt,
  input  wire logic        [pis_pkg::FAC_W-1:0]  fac,
  input  wire logic signed [pis_pkg::WORD_W-1:0] vel_in,
  input  wire logic signed [pis_pkg::WORD_W-1:0] pos_in,
  input  wire logic signed [pis_pkg::WORD_W-1:0] grav_in,
  output logic      signed [pis_pkg::WORD_W-1:0] vel_out,
  output logic      signed [pis_pkg::WORD_W-1:0] pos_out
);
  import pis_pkg::*;

  logic signed [49:0] damp_prod;
  logic signed [48:0] step_prod;

  logic signed [32:0]       damp4;
  logic signed [WORD_W-1:0] pos4;
  logic signed [WORD_W-1:0] grav4;
  logic signed [WORD_W-1:0] vel5;
  logic signed [WORD_W-1:0] pos5;
  logic signed [32:0]       move6;
  logic signed [WORD_W-1:0] vel6;
  logic signed [WORD_W-1:0] pos6;

  assign damp_prod = vel_in * $signed({1'b0, fac});
  assign step_prod = vel5 * $signed({1'b0, dt});

  always_ff @(posedge clk) begin
    if (ce) begin
      damp4   <= 33'(damp_prod >>> FRAC_W);
      pos4    <= pos_in;
      grav4   <= grav_in;
      vel5    <= sat32(34'(damp4) - 34'(grav4));
      pos5    <= pos4;
      move6   <= 33'(step_prod >>> FRAC_W);
      vel6    <= vel5;
      pos6    <= pos5;
      vel_out <= vel6;
      pos_out <= sat32(34'(pos6) + 34'(move6));
    end
  end

endmodule

`default_nettype wire

// ===== design/particle_integrate_step.sv =====
`default_nettype none

// Advances one particle by one frame time per word. A new word is taken every clock cycle while the
// output word is taken or the last stage is empty; the seven register stages are the frame-time
// products, the drag table lookup, its interpolation, the velocity damping, the velocity clamp, the
// position step and the position clamp. The whole pipeline holds while the output word is not
// taken, so s_axis_tready follows m_axis_tready combinationally. The drag factor table is built
// at elaboration and needs no loading after reset.
module particle_integrate_step #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          frame_time_we,
  input  wire logic [pis_pkg::DT_W-1:0]      frame_time_wdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age, lifetime, drag_rate, gravity_accel,
  // sprite_size, growth_rate, two zero bits.
  input  wire logic [pis_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_age, new_size, alive.
  output logic [pis_pkg::OUT_W-1:0]          m_axis_tdata
);
  import pis_pkg::*;

  typedef struct packed {
    logic [AGE_W-1:0]         age;
    logic                     alive;
    logic signed [WORD_W-1:0] size;
  } side_t;

  logic [DT_W-1:0] frame_time;
  logic [7:1]      vld;
  logic            ce;

  logic signed [WORD_W-1:0] in_pos [3];
  logic signed [WORD_W-1:0] in_vel [3];
  logic [AGE_W-1:0]         in_age;
  logic [AGE_W-1:0]         in_life;
  logic [DRAG_W-1:0]        in_drag;
  logic signed [WORD_W-1:0] in_grav;
  logic signed [WORD_W-1:0] in_size;
  logic signed [WORD_W-1:0] in_grow;

  logic [DRAG_W+DT_W-1:0]   drag_prod;
  logic [AGE_W:0]           age_sum;
  logic signed [48:0]       grav_prod;
  logic signed [48:0]       grow_prod;

  logic [DRAG_W-1:0]        x1;
  logic [AGE_W-1:0]         age1;
  logic [AGE_W-1:0]         life1;
  logic signed [WORD_W-1:0] size1;
  logic signed [WORD_W-1:0] dsize1;
  logic signed [WORD_W-1:0] grav1;
  logic signed [WORD_W-1:0] grav2;
  logic signed [WORD_W-1:0] grav3;
  logic signed [WORD_W-1:0] pos1 [3];
  logic signed [WORD_W-1:0] pos2 [3];
  logic signed [WORD_W-1:0] pos3 [3];
  logic signed [WORD_W-1:0] vel1 [3];
  logic signed [WORD_W-1:0] vel2 [3];
  logic signed [WORD_W-1:0] vel3 [3];
  side_t                    side [2:7];

  logic [FAC_W-1:0]         fac;
  logic signed [WORD_W-1:0] grav_axis [3];
  logic signed [WORD_W-1:0] new_vel [3];
  logic signed [WORD_W-1:0] new_pos [3];

  assign ce            = !vld[7] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[7];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      in_pos[j] = s_axis_tdata[j*WORD_W +: WORD_W];
      in_vel[j] = s_axis_tdata[(3+j)*WORD_W +: WORD_W];
    end
  end
  assign in_age  = s_axis_tdata[222:192];
  assign in_life = s_axis_tdata[253:223];
  assign in_drag = s_axis_tdata[277:254];
  assign in_grav = s_axis_tdata[309:278];
  assign in_size = s_axis_tdata[341:310];
  assign in_grow = s_axis_tdata[373:342];

  assign drag_prod = in_drag * DRAG_W'(frame_time);
  assign age_sum   = {1'b0, in_age} + (AGE_W+1)'(frame_time);
  assign grav_prod = in_grav * $signed({1'b0, frame_time});
  assign grow_prod = in_grow * $signed({1'b0, frame_time});

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= 16'd1092;
      vld        <= '0;
    end else begin
      if (frame_time_we) begin
        frame_time <= frame_time_wdata;
      end
      if (ce) begin
        vld <= {vld[6:1], s_axis_tvalid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x1     <= drag_prod[DRAG_W+DT_W-1:FRAC_W];
      age1   <= age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];
      life1  <= in_life;
      size1  <= in_size;
      dsize1 <= WORD_W'(grow_prod >>> FRAC_W);
      grav1  <= WORD_W'(grav_prod >>> FRAC_W);
      grav2  <= grav1;
      grav3  <= grav2;
      for (int j = 0; j < 3; j++) begin
        pos1[j] <= in_pos[j];
        pos2[j] <= pos1[j];
        pos3[j] <= pos2[j];
        vel1[j] <= in_vel[j];
        vel2[j] <= vel1[j];
        vel3[j] <= vel2[j];
      end
      side[2].age   <= age1;
      side[2].alive <= (age1 < life1);
      side[2].size  <= sat32(34'(size1) + 34'(dsize1));
      for (int s = 3; s <= 7; s++) begin
        side[s] <= side[s-1];
      end
    end
  end

  pis_drag_factor #(
    .DEPTH(EXP_TABLE_DEPTH)
  ) u_factor (
    .clk (clk),
    .ce  (ce),
    .x_in(x1),
    .fac (fac)
  );

  assign grav_axis[0] = '0;
  assign grav_axis[1] = '0;
  assign grav_axis[2] = grav3;

  for (genvar j = 0; j < 3; j++) begin : g_axis
    pis_axis u_axis (
      .clk    (clk),
      .ce     (ce),
      .dt     (frame_time),
      .fac    (fac),
      .vel_in (vel3[j]),
      .pos_in (pos3[j]),
      .grav_in(grav_axis[j]),
      .vel_out(new_vel[j]),
      .pos_out(new_pos[j])
    );
  end

  assign m_axis_tdata = {side[7].alive, side[7].size, side[7].age,
                         new_vel[2], new_vel[1], new_vel[0],
                         new_pos[2], new_pos[1], new_pos[0]};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid directly after reset");

  a_fac_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> fac <= FAC_ONE)
    else $error("drag factor above one");

  a_alive_age: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && side[7].alive |-> side[7].age != '1)
    else $error("alive with a saturated age");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vld[1] && !ce |=> vld[1] && $stable(x1) && $stable(age1))
    else $error("first stage changed during a stall");

endmodule

`default_nettype wire

// ===== tb/sv/particle_integrate_step_tb.sv =====
`default_nettype none

module particle_integrate_step_tb;
  import pis_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    int pos[3];
    int vel[3];
    bit [30:0] age;
    bit [30:0] lifetime;
    bit [23:0] drag;
    int gravity;
    int size;
    int growth;
  } particle_t;

  typedef struct {
    int pos[3];
    int vel[3];
    bit [30:0] age;
    int size;
    bit alive;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic frame_time_we = 1'b0;
  logic [DT_W-1:0] frame_time_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  particle_integrate_step u_top (
    .clk(clk), .rst(rst),
    .frame_time_we(frame_time_we), .frame_time_wdata(frame_time_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  particle_t particles_waiting[$];
  update_t updates_due[$];
  int unsigned exp_rom[0:TABLE_DEPTH];
  longint dt_now = 1092;
  int sender_idle = 0;
  int receiver_idle = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int errors = 0;
  int words_checked = 0;
  int expired_seen = 0;
  int cycles = 0;
  bit took_input = 1'b0;

  function automatic longint unsigned mul_q56(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[119:56];
  endfunction

  function automatic void build_exp_rom();
    longint unsigned y, term, sum, cur;
    y = (64'd1 << 60) / TABLE_DEPTH;
    term = 64'd1 << 56;
    sum = term;
    cur = term;
    for (int k = 1; k <= 24; k++) begin
      term = mul_q56(term, y) / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    exp_rom[0] = 65536;
    for (int i = 1; i <= TABLE_DEPTH; i++) begin
      cur = mul_q56(cur, sum);
      exp_rom[i] = 32'((cur + (64'd1 << 39)) >> 40);
    end
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic update_t advance(particle_t p);
    update_t r;
    longint unsigned nage, x, ph, fi, ff, a, b, fac;
    longint v;
    nage = longint'(p.age) + dt_now;
    if (nage > 64'h7FFF_FFFF) nage = 64'h7FFF_FFFF;
    x = (longint'(p.drag) * dt_now) >> 16;
    if (x >= (64'd16 << 16)) begin
      fac = 0;
    end else begin
      ph = x * TABLE_DEPTH;
      fi = ph >> 20;
      ff = ph & 64'hF_FFFF;
      a = exp_rom[fi];
      b = exp_rom[fi + 1];
      fac = a - (((a - b) * ff) >> 20);
    end
    for (int j = 0; j < 3; j++) begin
      v = (longint'(p.vel[j]) * longint'(fac)) >>> 16;
      if (j == 2) v = v - ((longint'(p.gravity) * dt_now) >>> 16);
      r.vel[j] = int'(clamp32(v));
      r.pos[j] = int'(clamp32(longint'(p.pos[j]) + ((longint'(r.vel[j]) * dt_now) >>> 16)));
    end
    r.size = int'(clamp32(longint'(p.size) + ((longint'(p.growth) * dt_now) >>> 16)));
    r.age = nage[30:0];
    r.alive = nage < longint'(p.lifetime);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_particle(particle_t p);
    return {2'b00, p.growth, p.size, p.gravity, p.drag, p.lifetime, p.age,
            p.vel[2], p.vel[1], p.vel[0], p.pos[2], p.pos[1], p.pos[0]};
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d updates outstanding.", updates_due.size());
      $display("== FAIL ==");
      $finish;
    end
    took_input <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      updates_due = {updates_due, advance(particles_waiting.pop_front())};
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (updates_due.size() == 0) begin
        $display("%0t unexpected word: expected none actual %0h", $time, m_axis_tdata);
        errors++;
      end else begin
        update_t e;
        e = updates_due.pop_front();
        for (int j = 0; j < 3; j++) begin
          compare_field($sformatf("new_pos[%0d]", j), e.pos[j], int'(m_axis_tdata[32*j +: 32]));
          compare_field($sformatf("new_vel[%0d]", j), e.vel[j],
                        int'(m_axis_tdata[96 + 32*j +: 32]));
        end
        compare_field("new_age", e.age, m_axis_tdata[222:192]);
        compare_field("new_size", e.size, int'(m_axis_tdata[254:223]));
        compare_field("alive", e.alive, m_axis_tdata[255]);
        words_checked++;
        if (!e.alive) expired_seen++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || took_input) begin
      if (particles_waiting.size() > 0 && $urandom_range(99) >= sender_idle) begin
        s_axis_tdata <= pack_particle(particles_waiting[0]);
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_requests != holds_done) begin
      hold_left = HOLD_CYCLES;
      holds_done = holds_done + 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= receiver_idle;
    end
  end

  function automatic int random_word();
    case ($urandom_range(5))
      0: return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : -32'sh8000_0000;
      1: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      2: return int'($urandom_range(0, 1 << 16)) - (1 << 15);
      default: return int'($urandom);
    endcase
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    for (int j = 0; j < 3; j++) begin
      p.pos[j] = random_word();
      p.vel[j] = random_word();
    end
    p.gravity = random_word();
    p.size = random_word();
    p.growth = random_word();
    case ($urandom_range(3))
      0: p.drag = 24'($urandom);
      1: p.drag = 24'($urandom_range(0, 1 << 18));
      2: p.drag = 24'($urandom_range(0, 1 << 12));
      default: p.drag = $urandom_range(1, 0) ? 24'hFF_FFFF : 24'd0;
    endcase
    p.age = 31'($urandom);
    if ($urandom_range(1)) begin
      p.lifetime = 31'($urandom);
    end else begin
      if (p.age > 31'h7FFF_0000) p.age = 31'($urandom_range(0, 1 << 24));
      p.lifetime = 31'(p.age + $urandom_range(0, 2 * 65536));
    end
    return p;
  endfunction

  function automatic particle_t plain_particle(int fill, bit [23:0] drag, bit [30:0] age,
                                               bit [30:0] lifetime);
    particle_t p;
    for (int j = 0; j < 3; j++) begin
      p.pos[j] = fill;
      p.vel[j] = fill;
    end
    p.gravity = fill;
    p.size = fill;
    p.growth = fill;
    p.drag = drag;
    p.age = age;
    p.lifetime = lifetime;
    return p;
  endfunction

  task automatic queue_particle(particle_t p);
    particles_waiting = {particles_waiting, p};
  endtask

  task automatic wait_drained();
    while (particles_waiting.size() > 0 || updates_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_frame_time(bit [15:0] value);
    @(negedge clk);
    frame_time_we <= 1'b1;
    frame_time_wdata <= value;
    @(negedge clk);
    frame_time_we <= 1'b0;
    dt_now = value;
  endtask

  task automatic push_directed();
    queue_particle(plain_particle(0, 24'd0, 31'd0, 31'd0));
    queue_particle(plain_particle(32'sh7FFF_FFFF, 24'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    queue_particle(plain_particle(-32'sh8000_0000, 24'd0, 31'd0, 31'h7FFF_FFFF));
    queue_particle(plain_particle(-32'sh8000_0000, 24'hFF_FFFF, 31'd5, 31'd0));
    queue_particle(plain_particle(32'sh7FFF_FFFF, 24'hFF_FFFF, 31'd100, 31'd101));
    queue_particle(plain_particle(32'sh0001_0000, 24'h01_0000, 31'd0, 31'd1));
    queue_particle(plain_particle(-32'sh0003_8000, 24'h03_1234, 31'd10, 31'd5));
    queue_particle(plain_particle(32'sh0100_0000, 24'h80_0000, 31'h7FFF_FF00, 31'h7FFF_FFFF));
    queue_particle(plain_particle(-32'sh0000_0001, 24'h00_0001, 31'd0, 31'(dt_now)));
    queue_particle(plain_particle(-32'sh0000_0001, 24'h00_0001, 31'd0, 31'(dt_now + 1)));
    queue_particle(plain_particle(32'sh5555_5555, 24'hAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555));
    queue_particle(plain_particle(-32'sh5555_5556, 24'h55_5555, 31'h5555_5555, 31'h2AAA_AAAA));
  endtask

  task automatic push_random(int count);
    for (int n = 0; n < count; n++) queue_particle(random_particle());
  endtask

  initial begin
    build_exp_rom();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle = 17;
    receiver_idle = 60;
    push_directed();
    wait_drained();
    write_frame_time(16'hFFFF);
    push_directed();
    push_random(200);
    wait_drained();
    write_frame_time(16'd0);
    push_directed();
    push_random(150);
    wait_drained();

    sender_idle = 60;
    receiver_idle = 17;
    write_frame_time(16'd1092);
    push_random(400);
    wait_drained();
    write_frame_time(16'($urandom));
    push_random(250);
    wait_drained();

    sender_idle = 0;
    receiver_idle = 0;
    write_frame_time(16'd1);
    push_directed();
    push_random(400);
    hold_requests = hold_requests + 1;
    wait_drained();
    write_frame_time(16'($urandom_range(16384, 32768)));
    push_random(200);
    wait_drained();

    $display("Checked %0d particle updates, %0d of them expired, over six frame times.",
             words_checked, expired_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/pis_pkg.sv
design/pis_drag_factor.sv
design/pis_axis.sv
design/particle_integrate_step.sv
tb/sv/particle_integrate_step_tb.sv
